// File: design/ogru_pkg.sv
package ogru_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;

   localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W   = $clog2(CELLS + 1);
   localparam int X_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EW_W    = $clog2(MAX_WIDTH + 1);
   localparam int EH_W    = $clog2(MAX_HEIGHT + 1);

   localparam int COORD_W   = 16;
   localparam int DATA_W    = 8;
   localparam int DIM_W     = 8;
   localparam int CMD_W     = 2;
   localparam int ERR_W     = COORD_W + 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int Q_DEPTH   = 2;

   typedef enum logic [CMD_W-1:0] {
      OP_TRACE  = 2'd0,
      OP_UPDATE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH     = 3'd0,
      REG_GRID_HEIGHT    = 3'd1,
      REG_FREE_DELTA     = 3'd2,
      REG_OCCUPIED_DELTA = 3'd3,
      REG_MAX_LOG_ODDS   = 3'd4,
      REG_MIN_LOG_ODDS   = 3'd5,
      REG_UNKNOWN_VALUE  = 3'd6
   } csr_reg_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_STEP,
      B_READ,
      B_MODIFY,
      B_CLEAR,
      B_RESP
   } back_state_type;

   typedef struct packed {
      logic        [DIM_W-1:0]  grid_width;
      logic        [DIM_W-1:0]  grid_height;
      logic signed [DATA_W-1:0] free_delta;
      logic signed [DATA_W-1:0] occupied_delta;
      logic signed [DATA_W-1:0] max_log_odds;
      logic signed [DATA_W-1:0] min_log_odds;
      logic signed [DATA_W-1:0] unknown_value;
   } cfg_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type                    op;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [ERR_W-1:0]   dx;
      logic signed [ERR_W-1:0]   dy;
      logic signed [ERR_W-1:0]   err;
      logic                      sx_neg;
      logic                      sy_neg;
      logic                      mark;
      logic signed [DATA_W-1:0]  delta;
   } cmd_type;

endpackage

// File: design/ogru_if.sv
interface ogru_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [ogru_pkg::CMD_W-1:0]    cmd;
   logic signed [ogru_pkg::COORD_W-1:0]  start_x;
   logic signed [ogru_pkg::COORD_W-1:0]  start_y;
   logic signed [ogru_pkg::COORD_W-1:0]  end_x;
   logic signed [ogru_pkg::COORD_W-1:0]  end_y;
   logic                                 mark_end;
   logic signed [ogru_pkg::DATA_W-1:0]   delta;

   modport source (output valid, cmd, start_x, start_y, end_x, end_y, mark_end, delta,
                   input ready);
   modport sink (input valid, cmd, start_x, start_y, end_x, end_y, mark_end, delta,
                 output ready);
endinterface

interface ogru_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               status;
   logic signed [ogru_pkg::DATA_W-1:0] cell_value;

   modport source (output valid, status, cell_value, input ready);
   modport sink (input valid, status, cell_value, output ready);
endinterface

// File: design/occupancy_grid_ray_update.sv
// channel  dir  handshake          payload
// req_ch   in   valid/ready        cmd, start_x, start_y, end_x, end_y, mark_end, delta
// rsp_ch   out  valid/ready        status, cell_value
// csr_*    in   csr_we, no ready   csr_index, csr_wdata
//
// read or update: STEP, READ, MODIFY and RESP on the grid, STEP and RESP off it
// trace: every ray cell passes STEP, a cell on the grid also READ and MODIFY (the end cell only when marked)
// clear: one store write per cycle over the clamped grid_width * grid_height cells
// after reset the store is zeroed while req_ch.ready is low
// two commands queue between front and back; a waiting result beat stalls the back
// only once its next result is ready
module occupancy_grid_ray_update (
   input  logic                               clock,
   input  logic                               reset,
   ogru_req_if.sink                           req_ch,
   ogru_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [ogru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ogru_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ogru_pkg::cfg_type cfg_ff, cfg_in;
   ogru_pkg::cmd_type push_data, pop_data;
   logic              push, q_full, q_pop, q_valid, init_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ogru_pkg::REG_GRID_WIDTH:     cfg_in.grid_width     = csr_wdata;
            ogru_pkg::REG_GRID_HEIGHT:    cfg_in.grid_height    = csr_wdata;
            ogru_pkg::REG_FREE_DELTA:     cfg_in.free_delta     = $signed(csr_wdata);
            ogru_pkg::REG_OCCUPIED_DELTA: cfg_in.occupied_delta = $signed(csr_wdata);
            ogru_pkg::REG_MAX_LOG_ODDS:   cfg_in.max_log_odds   = $signed(csr_wdata);
            ogru_pkg::REG_MIN_LOG_ODDS:   cfg_in.min_log_odds   = $signed(csr_wdata);
            ogru_pkg::REG_UNKNOWN_VALUE:  cfg_in.unknown_value  = $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width     <= ogru_pkg::DIM_W'(128);
         cfg_ff.grid_height    <= ogru_pkg::DIM_W'(128);
         cfg_ff.free_delta     <= -8'sd1;
         cfg_ff.occupied_delta <= 8'sd3;
         cfg_ff.max_log_odds   <= 8'sd100;
         cfg_ff.min_log_odds   <= -8'sd100;
         cfg_ff.unknown_value  <= 8'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ogru_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .init_busy (init_busy),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   ogru_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (pop_data)
   );

   ogru_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp       (rsp_ch)
   );

endmodule

// File: design/ogru_ram.sv
module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/ogru_front.sv
module ogru_front (
   input  logic                      clock,
   input  logic                      reset,
   ogru_req_if.sink                  req,
   input  logic                      init_busy,
   input  logic                      q_full,
   output logic                      push,
   output ogru_pkg::cmd_type         push_data
);

   logic signed [ogru_pkg::ERR_W-1:0] x0e, y0e, x1e, y1e;
   logic signed [ogru_pkg::ERR_W-1:0] dx, dy;

   assign req.ready = !q_full && !init_busy;
   assign push      = req.valid && req.ready;

   always_comb begin
      x0e = ogru_pkg::ERR_W'(req.start_x);
      y0e = ogru_pkg::ERR_W'(req.start_y);
      x1e = ogru_pkg::ERR_W'(req.end_x);
      y1e = ogru_pkg::ERR_W'(req.end_y);
      // dx is the positive span, dy the negated one
      dx  = (x1e > x0e) ? (x1e - x0e) : (x0e - x1e);
      dy  = (y1e > y0e) ? (y0e - y1e) : (y1e - y0e);

      push_data.op     = ogru_pkg::op_type'(req.cmd);
      push_data.x0     = req.start_x;
      push_data.y0     = req.start_y;
      push_data.x1     = req.end_x;
      push_data.y1     = req.end_y;
      push_data.dx     = dx;
      push_data.dy     = dy;
      push_data.err    = dx + dy;
      push_data.sx_neg = !(x0e < x1e);
      push_data.sy_neg = !(y0e < y1e);
      push_data.mark   = req.mark_end;
      push_data.delta  = req.delta;
   end

   a_no_push_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !push)
      else $error("command taken during store initialization");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("command pushed into a full queue");

   a_op_matches: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.op == ogru_pkg::op_type'(req.cmd)))
      else $error("classified op differs from command");

endmodule

// File: design/ogru_queue.sv
module ogru_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ogru_pkg::cmd_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output ogru_pkg::cmd_type   pop_data
);

   localparam int PTR_W = (ogru_pkg::Q_DEPTH > 1) ? $clog2(ogru_pkg::Q_DEPTH) : 1;
   localparam int FILL_W = $clog2(ogru_pkg::Q_DEPTH + 1);

   ogru_pkg::cmd_type entry_ff [ogru_pkg::Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full      = (fill_ff == FILL_W'(ogru_pkg::Q_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ogru_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ogru_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ogru_pkg::Q_DEPTH))
      else $error("queue fill beyond depth");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill not tracking push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// File: design/ogru_back.sv
module ogru_back (
   input  logic                clock,
   input  logic                reset,
   input  ogru_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  ogru_pkg::cmd_type   q_data,
   output logic                q_pop,
   output logic                init_busy,
   ogru_rsp_if.source          rsp
);

   localparam int S_W = ogru_pkg::DATA_W + 1;

   ogru_pkg::back_state_type state_ff, state_in;

   ogru_pkg::op_type                    op_ff, op_in;
   logic signed [ogru_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ogru_pkg::COORD_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [ogru_pkg::ERR_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic                                sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic                                mark_ff, mark_in;
   logic signed [ogru_pkg::DATA_W-1:0]  delta_ff, delta_in;
   logic signed [ogru_pkg::DATA_W-1:0]  add_ff, add_in;
   logic                                last_ff, last_in;
   logic [ogru_pkg::ADDR_W-1:0]         idx_ff, idx_in;
   logic [ogru_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ogru_pkg::CNT_W-1:0]          clear_n_ff, clear_n_in;
   logic                                status_ff, status_in;
   logic signed [ogru_pkg::DATA_W-1:0]  val_ff, val_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_status_ff, rsp_status_in;
   logic signed [ogru_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;

   logic [ogru_pkg::EW_W-1:0]           ew;
   logic [ogru_pkg::EH_W-1:0]           eh;
   logic                                on_grid, at_end, step_x, step_y;
   logic signed [ogru_pkg::ERR_W:0]     e2;
   logic [ogru_pkg::CNT_W-1:0]          cur_idx;
   logic signed [S_W-1:0]               sum;
   logic signed [ogru_pkg::DATA_W-1:0]  sat;
   logic                                clear_done, rsp_load;

   logic                                ram_we, ram_re;
   logic [ogru_pkg::ADDR_W-1:0]         ram_waddr;
   logic [ogru_pkg::DATA_W-1:0]         ram_wdata, ram_rdata;

   ogru_ram #(
      .WIDTH (ogru_pkg::DATA_W),
      .DEPTH (ogru_pkg::CELLS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // grid size clamped to the store
   assign ew = (32'(cfg.grid_width) > ogru_pkg::MAX_WIDTH) ?
               ogru_pkg::EW_W'(ogru_pkg::MAX_WIDTH) : ogru_pkg::EW_W'(cfg.grid_width);
   assign eh = (32'(cfg.grid_height) > ogru_pkg::MAX_HEIGHT) ?
               ogru_pkg::EH_W'(ogru_pkg::MAX_HEIGHT) : ogru_pkg::EH_W'(cfg.grid_height);

   assign on_grid = !x_ff[ogru_pkg::COORD_W-1] && !y_ff[ogru_pkg::COORD_W-1] &&
                    (32'($unsigned(x_ff)) < 32'(ew)) && (32'($unsigned(y_ff)) < 32'(eh));
   assign at_end = (x_ff == x1_ff) && (y_ff == y1_ff);

   assign cur_idx = ogru_pkg::CNT_W'(y_ff[ogru_pkg::Y_W-1:0]) * ogru_pkg::CNT_W'(ew)
                  + ogru_pkg::CNT_W'(x_ff[ogru_pkg::X_W-1:0]);

   assign e2     = $signed({err_ff, 1'b0});
   assign step_x = (e2 >= (ogru_pkg::ERR_W + 1)'(dy_ff));
   assign step_y = (e2 <= (ogru_pkg::ERR_W + 1)'(dx_ff));

   // saturate: upper limit checked first
   assign sum = S_W'($signed(ram_rdata)) + S_W'(add_ff);
   always_comb begin
      if (sum > S_W'(cfg.max_log_odds)) begin
         sat = cfg.max_log_odds;
      end else if (sum < S_W'(cfg.min_log_odds)) begin
         sat = cfg.min_log_odds;
      end else begin
         sat = sum[ogru_pkg::DATA_W-1:0];
      end
   end

   assign clear_done = (cnt_ff == clear_n_ff);
   assign rsp_load   = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ogru_pkg::B_INIT: begin
            if (cnt_ff == ogru_pkg::CNT_W'(ogru_pkg::CELLS - 1)) begin
               state_in = ogru_pkg::B_IDLE;
            end
         end
         ogru_pkg::B_IDLE: begin
            if (q_valid) begin
               state_in = (q_data.op == ogru_pkg::OP_CLEAR) ? ogru_pkg::B_CLEAR : ogru_pkg::B_STEP;
            end
         end
         ogru_pkg::B_STEP: begin
            if (op_ff == ogru_pkg::OP_TRACE) begin
               if (at_end) begin
                  state_in = (mark_ff && on_grid) ? ogru_pkg::B_READ : ogru_pkg::B_RESP;
               end else if (on_grid) begin
                  state_in = ogru_pkg::B_READ;
               end
            end else begin
               state_in = on_grid ? ogru_pkg::B_READ : ogru_pkg::B_RESP;
            end
         end
         ogru_pkg::B_READ:   state_in = ogru_pkg::B_MODIFY;
         ogru_pkg::B_MODIFY: state_in = last_ff ? ogru_pkg::B_RESP : ogru_pkg::B_STEP;
         ogru_pkg::B_CLEAR: begin
            if (clear_done) begin
               state_in = ogru_pkg::B_RESP;
            end
         end
         ogru_pkg::B_RESP: begin
            if (rsp_load) begin
               state_in = ogru_pkg::B_IDLE;
            end
         end
         default: state_in = ogru_pkg::B_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      init_busy = 1'b0;
      ram_re    = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = sat;
      unique case (state_ff)
         ogru_pkg::B_INIT: begin
            init_busy = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ogru_pkg::ADDR_W-1:0];
            ram_wdata = '0;
         end
         ogru_pkg::B_IDLE:   q_pop = q_valid;
         ogru_pkg::B_READ:   ram_re = 1'b1;
         ogru_pkg::B_MODIFY: ram_we = (op_ff != ogru_pkg::OP_READ);
         ogru_pkg::B_CLEAR: begin
            ram_we    = !clear_done;
            ram_waddr = cnt_ff[ogru_pkg::ADDR_W-1:0];
            ram_wdata = cfg.unknown_value;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in      = op_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      err_in     = err_ff;
      sx_neg_in  = sx_neg_ff;
      sy_neg_in  = sy_neg_ff;
      mark_in    = mark_ff;
      delta_in   = delta_ff;
      add_in     = add_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      clear_n_in = clear_n_ff;
      status_in  = status_ff;
      val_in     = val_ff;
      case (state_ff)
         ogru_pkg::B_INIT: cnt_in = cnt_ff + 1'b1;
         ogru_pkg::B_IDLE: begin
            if (q_valid) begin
               op_in      = q_data.op;
               x_in       = q_data.x0;
               y_in       = q_data.y0;
               x1_in      = q_data.x1;
               y1_in      = q_data.y1;
               dx_in      = q_data.dx;
               dy_in      = q_data.dy;
               err_in     = q_data.err;
               sx_neg_in  = q_data.sx_neg;
               sy_neg_in  = q_data.sy_neg;
               mark_in    = q_data.mark;
               delta_in   = q_data.delta;
               cnt_in     = '0;
               clear_n_in = ogru_pkg::CNT_W'(ew) * ogru_pkg::CNT_W'(eh);
               status_in  = 1'b0;
               val_in     = '0;
            end
         end
         ogru_pkg::B_STEP: begin
            idx_in = cur_idx[ogru_pkg::ADDR_W-1:0];
            if (op_ff == ogru_pkg::OP_TRACE) begin
               last_in = at_end;
               add_in  = at_end ? cfg.occupied_delta : cfg.free_delta;
               if (!at_end) begin
                  err_in = err_ff + (step_x ? dy_ff : '0) + (step_y ? dx_ff : '0);
                  if (step_x) begin
                     x_in = sx_neg_ff ? x_ff - ogru_pkg::COORD_W'(1) : x_ff + ogru_pkg::COORD_W'(1);
                  end
                  if (step_y) begin
                     y_in = sy_neg_ff ? y_ff - ogru_pkg::COORD_W'(1) : y_ff + ogru_pkg::COORD_W'(1);
                  end
               end
            end else begin
               last_in   = 1'b1;
               add_in    = delta_ff;
               status_in = !on_grid;
            end
         end
         ogru_pkg::B_MODIFY: begin
            if (op_ff == ogru_pkg::OP_READ) begin
               val_in = $signed(ram_rdata);
            end else if (op_ff == ogru_pkg::OP_UPDATE) begin
               val_in = sat;
            end
         end
         ogru_pkg::B_CLEAR: begin
            if (!clear_done) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result register keeps the back running while a beat waits downstream
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (state_ff == ogru_pkg::B_RESP && rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ogru_pkg::B_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      err_ff        <= err_in;
      sx_neg_ff     <= sx_neg_in;
      sy_neg_ff     <= sy_neg_in;
      mark_ff       <= mark_in;
      delta_ff      <= delta_in;
      add_ff        <= add_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      clear_n_ff    <= clear_n_in;
      status_ff     <= status_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.cell_value = rsp_value_ff;

   a_read_then_modify: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (state_ff == ogru_pkg::B_MODIFY))
      else $error("store read not followed by modify");

   a_trace_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ogru_pkg::B_RESP &&
       (op_ff == ogru_pkg::OP_TRACE || op_ff == ogru_pkg::OP_CLEAR)) |-> !status_ff)
      else $error("trace or clear reporting out-of-grid");

   a_clear_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ogru_pkg::B_CLEAR) |-> (cnt_ff <= clear_n_ff))
      else $error("clear sweep past grid size");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ogru_pkg::B_IDLE) |-> !q_pop)
      else $error("queue popped while busy");

endmodule

// File: tb/grid_checker.sv
module grid_checker
   import ogru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ogru_req_if                   req_mon,
   ogru_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic                     status;
      logic signed [DATA_W-1:0] cell_value;
   } grid_rsp_t;

   logic signed [DATA_W-1:0] cell_mem [CELLS];
   cfg_type                  cfg;
   grid_rsp_t                rsp_q [$];
   grid_rsp_t                want;
   grid_rsp_t                got;

   function automatic void load_defaults();
      for (int i = 0; i < CELLS; i++) cell_mem[i] = '0;
      cfg.grid_width     = 8'd128;
      cfg.grid_height    = 8'd128;
      cfg.free_delta     = -8'sd1;
      cfg.occupied_delta = 8'sd3;
      cfg.max_log_odds   = 8'sd100;
      cfg.min_log_odds   = -8'sd100;
      cfg.unknown_value  = 8'sd0;
   endfunction

   function automatic void write_cfg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_GRID_WIDTH:     cfg.grid_width     = val;
         REG_GRID_HEIGHT:    cfg.grid_height    = val;
         REG_FREE_DELTA:     cfg.free_delta     = val;
         REG_OCCUPIED_DELTA: cfg.occupied_delta = val;
         REG_MAX_LOG_ODDS:   cfg.max_log_odds   = val;
         REG_MIN_LOG_ODDS:   cfg.min_log_odds   = val;
         REG_UNKNOWN_VALUE:  cfg.unknown_value  = val;
         default: ;
      endcase
   endfunction

   function automatic int used_cols();
      return (int'(cfg.grid_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg.grid_width);
   endfunction

   function automatic int used_rows();
      return (int'(cfg.grid_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg.grid_height);
   endfunction

   function automatic bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < used_cols() && y < used_rows();
   endfunction

   // upper limit wins when the limits are crossed
   function automatic logic signed [DATA_W-1:0] clamp_sum(int v);
      if (v > int'($signed(cfg.max_log_odds))) return cfg.max_log_odds;
      if (v < int'($signed(cfg.min_log_odds))) return cfg.min_log_odds;
      return DATA_W'(v);
   endfunction

   function automatic bit add_to_cell(int x, int y, int d,
                                      output logic signed [DATA_W-1:0] nv);
      int idx;
      nv = '0;
      if (!on_grid(x, y)) return 1'b0;
      idx = y * used_cols() + x;
      cell_mem[idx] = clamp_sum(int'(cell_mem[idx]) + d);
      nv = cell_mem[idx];
      return 1'b1;
   endfunction

   function automatic void walk_ray(int x0, int y0, int x1, int y1, bit mark);
      int dx, dy, sx, sy, err, e2;
      logic signed [DATA_W-1:0] nv;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y0 - y1 : y1 - y0;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      while (!(x0 == x1 && y0 == y1)) begin
         void'(add_to_cell(x0, y0, int'($signed(cfg.free_delta)), nv));
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            x0  += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            y0  += sy;
         end
      end
      if (mark) void'(add_to_cell(x0, y0, int'($signed(cfg.occupied_delta)), nv));
   endfunction

   function automatic grid_rsp_t predict_result(logic [CMD_W-1:0] op,
                                                int sx, int sy, int ex, int ey,
                                                bit mark, int d);
      grid_rsp_t r;
      logic signed [DATA_W-1:0] nv;
      int n;
      r = '0;
      case (op)
         OP_TRACE: walk_ray(sx, sy, ex, ey, mark);
         OP_UPDATE: begin
            if (add_to_cell(sx, sy, d, nv)) r.cell_value = nv;
            else r.status = 1'b1;
         end
         OP_READ: begin
            if (on_grid(sx, sy)) r.cell_value = cell_mem[sy * used_cols() + sx];
            else r.status = 1'b1;
         end
         default: begin
            n = used_cols() * used_rows();
            for (int i = 0; i < n; i++) cell_mem[i] = cfg.unknown_value;
         end
      endcase
      return r;
   endfunction

   task automatic report(string msg);
      if (fail_count < 40) $display("grid_checker: %s", msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_defaults();
         rsp_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) write_cfg(csr_index, csr_wdata);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status     = rsp_mon.status;
            got.cell_value = rsp_mon.cell_value;
            if (rsp_q.size() == 0) begin
               report($sformatf("result beat with nothing pending: status %0b value %0d",
                                got.status, got.cell_value));
            end else begin
               want = rsp_q.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status got %0b want %0b", got.status, want.status));
               if (got.cell_value !== want.cell_value)
                  report($sformatf("cell_value got %0d want %0d",
                                   got.cell_value, want.cell_value));
            end
         end
         if (req_mon.valid && req_mon.ready)
            rsp_q.push_back(predict_result(req_mon.cmd,
                                           int'(req_mon.start_x), int'(req_mon.start_y),
                                           int'(req_mon.end_x), int'(req_mon.end_y),
                                           req_mon.mark_end, int'(req_mon.delta)));
         outstanding <= rsp_q.size();
      end
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   import ogru_pkg::*;

   localparam int CYCLE_LIMIT = 6_000_000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_CHOKE} sink_mode_t;

   typedef struct packed {
      op_type                    cmd;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic                      mark;
      logic signed [DATA_W-1:0]  delta;
   } grid_cmd_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  sink_ready = 1'b0;
   sink_mode_t            sink_mode;
   int                    sink_left;
   int                    fail_count;
   int                    outstanding;
   int                    cycle_count;
   int                    aim_cols;
   int                    aim_rows;

   ogru_req_if req_ch ();
   ogru_rsp_if rsp_ch ();

   assign rsp_ch.ready = sink_ready;

   occupancy_grid_ray_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   grid_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: switches between open, coin-flip and mostly-stalled stretches
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         sink_left  <= 0;
      end else begin
         if (sink_left == 0) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
            sink_left <= $urandom_range(8, 150);
         end else begin
            sink_left <= sink_left - 1;
         end
         case (sink_mode)
            SINK_OPEN: sink_ready <= 1'b1;
            SINK_COIN: sink_ready <= 1'($urandom);
            default:   sink_ready <= (sink_left % 13 == 0);
         endcase
      end
   end

   function automatic grid_cmd_t mk(op_type op, int sx, int sy, int ex, int ey,
                                    bit mark, int d);
      grid_cmd_t c;
      c.cmd   = op;
      c.sx    = COORD_W'(sx);
      c.sy    = COORD_W'(sy);
      c.ex    = COORD_W'(ex);
      c.ey    = COORD_W'(ey);
      c.mark  = mark;
      c.delta = DATA_W'(d);
      return c;
   endfunction

   // mostly on the grid or just past its edges, sometimes anywhere in the coordinate range
   function automatic logic signed [COORD_W-1:0] pick_coord(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return COORD_W'(int'($urandom_range(0, span + 4)) - 2);
      if (r < 95) return COORD_W'($urandom);
      return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
   endfunction

   function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 40)) - 20;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return COORD_W'(v);
   endfunction

   function automatic grid_cmd_t random_cmd();
      grid_cmd_t c;
      int r, lx, ly;
      r       = $urandom_range(0, 199);
      c.mark  = 1'($urandom);
      c.delta = DATA_W'($urandom);
      c.sx    = pick_coord(aim_cols);
      c.sy    = pick_coord(aim_rows);
      c.ex    = pick_coord(aim_cols);
      c.ey    = pick_coord(aim_rows);
      if (r < 90) begin
         c.cmd = OP_TRACE;
         lx = int'(c.ex) - int'(c.sx);
         ly = int'(c.ey) - int'(c.sy);
         // long rays off the grid cost a cycle per cell, keep them short
         if (lx > 300 || lx < -300 || ly > 300 || ly < -300 || $urandom_range(0, 2) == 0) begin
            c.ex = nudge(c.sx);
            c.ey = nudge(c.sy);
         end
      end else if (r < 140) begin
         c.cmd = OP_UPDATE;
      end else if (r < 197) begin
         c.cmd = OP_READ;
      end else begin
         c.cmd = OP_CLEAR;
      end
      return c;
   endfunction

   task automatic drive_beat(grid_cmd_t c);
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= c.cmd;
      req_ch.start_x  <= c.sx;
      req_ch.start_y  <= c.sy;
      req_ch.end_x    <= c.ex;
      req_ch.end_y    <= c.ey;
      req_ch.mark_end <= c.mark;
      req_ch.delta    <= c.delta;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_grid(int w, int h, int fd, int od, int mx, int mn, int uv);
      write_reg(REG_GRID_WIDTH,     CSR_DATA_W'(w));
      write_reg(REG_GRID_HEIGHT,    CSR_DATA_W'(h));
      write_reg(REG_FREE_DELTA,     CSR_DATA_W'(fd));
      write_reg(REG_OCCUPIED_DELTA, CSR_DATA_W'(od));
      write_reg(REG_MAX_LOG_ODDS,   CSR_DATA_W'(mx));
      write_reg(REG_MIN_LOG_ODDS,   CSR_DATA_W'(mn));
      write_reg(REG_UNKNOWN_VALUE,  CSR_DATA_W'(uv));
      write_reg(REG_SPARE,          CSR_DATA_W'($urandom));
      csr_we   <= 1'b0;
      aim_cols  = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      aim_rows  = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
   endtask

   task automatic run_random(int n);
      int sent, burst, gap;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 12);
         gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         for (int k = 0; k < burst && sent < n; k++) begin
            drive_beat(random_cmd());
            sent++;
         end
         if ($urandom_range(0, 14) == 0) begin
            settle();
         end else if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      settle();
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= OP_TRACE;
      req_ch.start_x  <= '0;
      req_ch.start_y  <= '0;
      req_ch.end_x    <= '0;
      req_ch.end_y    <= '0;
      req_ch.mark_end <= 1'b0;
      req_ch.delta    <= '0;
      aim_cols         = MAX_WIDTH;
      aim_rows         = MAX_HEIGHT;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, directed corners
      drive_beat(mk(OP_READ,   0, 0, 0, 0, 0, 0));
      drive_beat(mk(OP_UPDATE, 0, 0, 0, 0, 0, 127));
      drive_beat(mk(OP_UPDATE, 127, 127, 0, 0, 1, -128));
      drive_beat(mk(OP_UPDATE, 128, 5, 0, 0, 0, 1));
      drive_beat(mk(OP_READ,   -1, 0, 0, 0, 0, 0));
      drive_beat(mk(OP_READ,   5, 128, 0, 0, 0, 0));
      drive_beat(mk(OP_READ,   -32768, 32767, -1, -1, 1, -1));
      drive_beat(mk(OP_UPDATE, 32767, -32768, 0, 0, 0, 0));
      // zero-length rays, with and without the end mark
      drive_beat(mk(OP_TRACE,  5, 5, 5, 5, 1, 0));
      drive_beat(mk(OP_TRACE,  6, 6, 6, 6, 0, 0));
      drive_beat(mk(OP_TRACE,  0, 0, 20, 7, 1, 0));
      drive_beat(mk(OP_READ,   20, 7, 0, 0, 0, 0));
      drive_beat(mk(OP_TRACE,  3, 0, 0, 30, 0, 0));
      drive_beat(mk(OP_TRACE,  50, 50, 40, 60, 1, 0));
      drive_beat(mk(OP_TRACE,  -5, -5, 10, 10, 1, 0));
      // full-range rays that cross the grid
      drive_beat(mk(OP_TRACE,  -32768, -32768, 32767, 32767, 1, 0));
      drive_beat(mk(OP_TRACE,  32767, 3, -32768, 3, 0, 0));
      drive_beat(mk(OP_READ,   10, 10, 0, 0, 0, 0));
      drive_beat(mk(OP_READ,   64, 3, 0, 0, 0, 0));
      drive_beat(mk(OP_CLEAR,  0, 0, 0, 0, 0, 0));
      drive_beat(mk(OP_READ,   20, 7, 0, 0, 0, 0));
      drive_beat(mk(OP_UPDATE, 1, 1, 0, 0, 0, -1));
      settle();
      run_random(100);

      program_grid(16, 12, -5, 20, 60, -60, 7);
      run_random(100);

      // extremes, width above the maximum
      program_grid(255, 1, -128, 127, 127, -128, -128);
      run_random(100);

      // zero width: every cell off the grid
      program_grid(0, 5, 9, -9, 50, -50, 0);
      run_random(60);

      // crossed limits
      program_grid(9, 128, 127, -128, -20, 30, 127);
      run_random(100);

      // height above the maximum, old contents seen through a new row length
      program_grid(128, 255, 1, -1, 100, -100, 0);
      run_random(100);

      repeat (2) begin
         program_grid($urandom_range(0, 255), $urandom_range(1, 48),
                      int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                      $urandom_range(0, 127), -int'($urandom_range(0, 128)),
                      int'($urandom_range(0, 255)) - 128);
         run_random(120);
      end

      repeat (64) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
design/ogru_pkg.sv
design/ogru_if.sv
design/ogru_ram.sv
design/ogru_front.sv
design/ogru_queue.sv
design/ogru_back.sv
design/occupancy_grid_ray_update.sv
tb/grid_checker.sv
tb/tb_top.sv
